### rtl/sdec_pkg.sv
// ----------------------------------------------------------------------------
// sdec_pkg: shared types, constants and functions of the scratchpad decoder
// Command, status and configuration types, CRC-8 step and reading decode.
// ----------------------------------------------------------------------------
package sdec_pkg;

  // Scratchpad layout
  localparam int SCRATCH_BYTES = 9;
  localparam int STORE_DEPTH   = SCRATCH_BYTES - 1;
  localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W         = $clog2(SCRATCH_BYTES + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAMILY  = 1'b0,
    CFG_INVALID = 1'b1
  } cfg_reg_e;

  // Input operation codes
  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_ABSENT = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_GOOD   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_BADCRC = 2'd2
  } status_e;

  // Decoding constants
  localparam logic [7:0]  FAMILY_LEGACY   = 8'h10;
  localparam logic [7:0]  COUNT_PER_DEG   = 8'h10;
  localparam logic [15:0] REFINE_MASK     = 16'hFFF0;
  localparam logic [15:0] REFINE_OFFSET   = 16'd12;
  localparam logic [7:0]  CRC_POLY        = 8'h8C;

  typedef enum logic [1:0] {
    RES_9BIT  = 2'b00,
    RES_10BIT = 2'b01,
    RES_11BIT = 2'b10,
    RES_12BIT = 2'b11
  } resolution_e;

  // Classified command passed from front to back
  typedef enum logic [2:0] {
    CMD_ABSENT = 3'b001,
    CMD_FIRST  = 3'b010,
    CMD_NEXT   = 3'b100
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  // Configuration registers seen by the back end
  typedef struct packed {
    logic [7:0]  family;
    logic [15:0] invalid;
  } cfg_t;

  // One byte of the reflected 1-Wire CRC-8
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Form the reading in sixteenths of a degree from the stored bytes
  function automatic logic [15:0] decode_reading(
    input logic [7:0] family,
    input logic [7:0] b0,
    input logic [7:0] b1,
    input logic [7:0] b4,
    input logic [7:0] b6,
    input logic [7:0] b7
  );
    logic [15:0] raw;
    raw = {b1, b0};
    if (family == FAMILY_LEGACY) begin
      raw = raw << 3;
      if (b7 == COUNT_PER_DEG) begin
        raw = (raw & REFINE_MASK) + REFINE_OFFSET - {8'h00, b6};
      end
    end else begin
      case (resolution_e'(b4[6:5]))
        RES_9BIT:  raw = raw & ~16'd7;
        RES_10BIT: raw = raw & ~16'd3;
        RES_11BIT: raw = raw & ~16'd1;
        default:   raw = raw;
      endcase
    end
    return raw;
  endfunction

endpackage

### rtl/sdec_in_if.sv
// ----------------------------------------------------------------------------
// sdec_in_if: input channel of the scratchpad decoder
// Valid/ready channel carrying one scratchpad byte or a no-sensor event.
// ----------------------------------------------------------------------------
interface sdec_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] scratch_byte;
  logic       start_of_read;

  modport source (output valid, output operation, output scratch_byte,
                  output start_of_read, input ready);
  modport sink   (input valid, input operation, input scratch_byte,
                  input start_of_read, output ready);
endinterface

### rtl/sdec_out_if.sv
// ----------------------------------------------------------------------------
// sdec_out_if: result channel of the scratchpad decoder
// Valid/ready channel carrying one temperature and its status.
// ----------------------------------------------------------------------------
interface sdec_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature;
  logic [1:0]         status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

### rtl/sdec_front.sv
// ----------------------------------------------------------------------------
// sdec_front: input side of the scratchpad decoder
// Accepts items, classifies them into commands and holds the config registers.
// ----------------------------------------------------------------------------
module sdec_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  sdec_in_if.sink                             in_ch,
  input  logic                                cfg_we_i,
  input  logic [sdec_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sdec_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                q_not_full_i,
  output logic                                push_o,
  output sdec_pkg::cmd_t                      cmd_o,
  output sdec_pkg::cfg_t                      cfg_o
);
  import sdec_pkg::*;

  logic [7:0]  family_q;
  logic [15:0] invalid_q;

  // Take an item whenever the queue has room
  assign in_ch.ready = q_not_full_i;
  assign push_o      = in_ch.valid && q_not_full_i;

  // Classify the item
  always_comb begin
    cmd_o.data = in_ch.scratch_byte;
    if (in_ch.operation == OP_ABSENT) begin
      cmd_o.kind = CMD_ABSENT;
    end else if (in_ch.start_of_read) begin
      cmd_o.kind = CMD_FIRST;
    end else begin
      cmd_o.kind = CMD_NEXT;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q  <= 8'h28;
      invalid_q <= 16'h8000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_FAMILY:  family_q  <= cfg_wdata_i[7:0];
        CFG_INVALID: invalid_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.family  = family_q;
  assign cfg_o.invalid = invalid_q;

endmodule

### rtl/sdec_queue.sv
// ----------------------------------------------------------------------------
// sdec_queue: command queue between front and back
// Small circular buffer of classified commands.
// ----------------------------------------------------------------------------
module sdec_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sdec_pkg::cmd_t cmd_i,
  output logic           not_full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sdec_pkg::cmd_t cmd_o
);
  import sdec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  cmd_t               mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W_Q-1:0] count_q, count_d;

  assign not_full_o = (count_q != CNT_W_Q'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign cmd_o      = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/sdec_back.sv
// ----------------------------------------------------------------------------
// sdec_back: execution side of the scratchpad decoder
// Runs the CRC, stores the scratchpad and registers the decoded result.
// ----------------------------------------------------------------------------
module sdec_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  sdec_pkg::cmd_t cmd_i,
  output logic           pop_o,
  input  sdec_pkg::cfg_t cfg_i,
  sdec_out_if.source     out_ch
);
  import sdec_pkg::*;

  logic [CNT_W-1:0] count_q, count_d, count_eff;
  logic [7:0]       crc_q, crc_d, crc_eff;
  logic [7:0]       store_q [STORE_DEPTH];
  logic             store_we;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      temp_q, temp_d;
  status_e          status_q, status_d;
  logic             res_valid;

  // Pop when the result register is free or being drained
  assign pop_o = q_valid_i && (!out_valid_q || out_ch.ready);

  // Restart the count on a start mark
  assign count_eff = (cmd_i.kind == CMD_FIRST) ? '0 : count_q;
  assign crc_eff   = (cmd_i.kind == CMD_FIRST) ? 8'h00 : crc_q;

  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    store_we  = 1'b0;
    res_valid = 1'b0;
    temp_d    = cfg_i.invalid;
    status_d  = ST_ABSENT;
    if (pop_o) begin
      case (cmd_i.kind)
        CMD_ABSENT: begin
          count_d   = '0;
          crc_d     = 8'h00;
          res_valid = 1'b1;
        end
        CMD_FIRST, CMD_NEXT: begin
          if (count_eff < CNT_W'(STORE_DEPTH)) begin
            store_we = 1'b1;
            crc_d    = crc8_update(crc_eff, cmd_i.data);
            count_d  = count_eff + 1'b1;
          end else begin
            res_valid = 1'b1;
            count_d   = '0;
            crc_d     = 8'h00;
            if (crc_eff == cmd_i.data) begin
              temp_d   = decode_reading(cfg_i.family, store_q[0], store_q[1],
                                        store_q[4], store_q[6], store_q[7]);
              status_d = ST_GOOD;
            end else begin
              status_d = ST_BADCRC;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      crc_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scratchpad store and result payload
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_eff[STORE_IDX_W-1:0]] <= cmd_i.data;
    end
    if (res_valid) begin
      temp_q   <= temp_d;
      status_q <= status_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.temperature = $signed(temp_q);
  assign out_ch.status      = status_q;

endmodule

### rtl/scratchpad_temperature_decoder_top.sv
// ----------------------------------------------------------------------------
// scratchpad_temperature_decoder_top: thermometer scratchpad decoder
// Checks the CRC-8 of a nine-byte scratchpad read and decodes the reading.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle: a scratchpad byte or a no-sensor
// event. Items enter a command queue of QUEUE_DEPTH entries; the back end
// pulls one command per cycle, so the input accepts one item every cycle as
// long as results are taken. A result (the ninth byte of a read, or a
// no-sensor event) is registered: its command is written into the queue, then
// loaded into the result register when popped, and transfers once the sink is
// ready. When the result register is stalled the queue fills and input ready
// drops once it holds QUEUE_DEPTH commands. Configuration is written through a
// plain write port (index 0: family code, index 1: invalid temperature); the
// user must write it only while idle, which the block does not enforce.
module scratchpad_temperature_decoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sdec_in_if.sink                         in_ch,
  sdec_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [sdec_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdec_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import sdec_pkg::*;

  logic push, pop, q_not_full, q_valid;
  cmd_t push_cmd, head_cmd;
  cfg_t cfg;

  sdec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_not_full_i (q_not_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .cfg_o        (cfg)
  );

  sdec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .cmd_i      (push_cmd),
    .not_full_o (q_not_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (head_cmd)
  );

  sdec_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .cmd_i     (head_cmd),
    .pop_o     (pop),
    .cfg_i     (cfg),
    .out_ch    (out_ch)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the scratchpad temperature decoder
// Scratchpad bytes and no-sensor events are fed through the input channel.
// A predictor tracks the CRC-8, byte count and stored bytes, and computes the
// expected temperature and status. Each returned result is checked against it
// under several family code and error value settings, with random gaps on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import sdec_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 9;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS   = 225;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 2_000_000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       mark;
  } scratch_item_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    status_e            status;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sdec_in_if  in_ch ();
  sdec_out_if out_ch ();

  scratchpad_temperature_decoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Stimulus and expectation stores
  scratch_item_t pending_items[$];
  reading_t      expected_readings[$];

  // Shadow copy of the decoder state and its registers
  logic [7:0]         family_sh;
  logic signed [15:0] invalid_sh;
  int                 count_sh;
  logic [7:0]         crc_sh;
  logic [7:0]         store_sh [0:STORE_DEPTH-1];

  // Run control and tallies
  logic in_done;
  bit   no_gaps;
  int   stall_requests;
  int   stall_served;
  int   hold_left;
  int   total_queued;
  int   items_in;
  int   mismatches;
  int   good_seen;
  int   absent_seen;
  int   badcrc_seen;

  // Clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // Serial form of the reflected CRC-8, one data bit per step, LSB first
  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  // Advance the shadow state by one accepted item, queue any result it causes
  task automatic predict_reading(logic op, logic [7:0] data, logic mark);
    reading_t    r;
    logic [15:0] raw;
    if (op == OP_ABSENT) begin
      count_sh      = 0;
      crc_sh        = 8'h00;
      r.temperature = invalid_sh;
      r.status      = ST_ABSENT;
      expected_readings.push_back(r);
    end else begin
      if (mark) begin
        count_sh = 0;
        crc_sh   = 8'h00;
      end
      if (count_sh < STORE_DEPTH) begin
        store_sh[count_sh] = data;
        crc_sh             = crc8_step(crc_sh, data);
        count_sh++;
      end else begin
        if (crc_sh == data) begin
          raw = {store_sh[1], store_sh[0]};
          if (family_sh == FAMILY_LEGACY) begin
            raw = raw << 3;
            // refine from count-remain when count-per-degree is nominal
            if (store_sh[7] == COUNT_PER_DEG) begin
              raw = (raw & REFINE_MASK) + REFINE_OFFSET - {8'h00, store_sh[6]};
            end
          end else begin
            case (resolution_e'(store_sh[4][6:5]))
              RES_9BIT:  raw = raw & ~16'd7;
              RES_10BIT: raw = raw & ~16'd3;
              RES_11BIT: raw = raw & ~16'd1;
              default:   raw = raw;
            endcase
          end
          r.temperature = raw;
          r.status      = ST_GOOD;
        end else begin
          r.temperature = invalid_sh;
          r.status      = ST_BADCRC;
        end
        expected_readings.push_back(r);
        count_sh = 0;
        crc_sh   = 8'h00;
      end
    end
  endtask

  // Driver: offer the next pending item, hold it until transfer
  always @(negedge clk_i) begin
    if (!in_ch.valid || in_done) begin
      if (pending_items.size() != 0 &&
          (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= pending_items[0].op;
        in_ch.scratch_byte  <= pending_items[0].data;
        in_ch.start_of_read <= pending_items[0].mark;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served <= stall_requests;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    reading_t want;
    in_done <= rst_ni && in_ch.valid && in_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_reading(in_ch.operation, in_ch.scratch_byte, in_ch.start_of_read);
        void'(pending_items.pop_front());
        items_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] unexpected result: temperature %0d status %0d", $realtime,
                     out_ch.temperature, out_ch.status);
          end
        end else begin
          want = expected_readings.pop_front();
          if (out_ch.temperature !== want.temperature) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] temperature mismatch: expected %0d, got %0d", $realtime,
                       want.temperature, out_ch.temperature);
            end
          end
          if (out_ch.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("[%0t] status mismatch: expected %0d, got %0d", $realtime,
                       want.status, out_ch.status);
            end
          end
          case (want.status)
            ST_GOOD:   good_seen++;
            ST_ABSENT: absent_seen++;
            default:   badcrc_seen++;
          endcase
        end
      end
    end
  end

  // Queue one stimulus item
  task automatic push_item(logic op, logic [7:0] data, logic mark);
    scratch_item_t it;
    it.op   = op;
    it.data = data;
    it.mark = mark;
    pending_items.push_back(it);
    total_queued++;
  endtask

  // Queue a nine-byte read: eight bytes and a good or corrupted CRC byte
  task automatic queue_scratchpad(logic [0:7][7:0] sp, bit mark, bit good_crc);
    logic [7:0] crc;
    crc = 8'h00;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      crc = crc8_step(crc, sp[i]);
      push_item(OP_BYTE, sp[i], (i == 0) ? mark : 1'b0);
    end
    if (!good_crc) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    push_item(OP_BYTE, crc, 1'b0);
  endtask

  // Write one configuration register while the decoder is idle
  task automatic write_register(cfg_reg_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FAMILY: family_sh = value[7:0];
      default:    invalid_sh = value;
    endcase
  endtask

  // Wait until every item is taken and every result is back, then settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_readings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed reads with random content, the rest noise
  task automatic run_random_phase(int target);
    logic [0:7][7:0] sp;
    int first;
    int pick;
    int k;
    first = total_queued;
    while (total_queued - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          sp[i] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 1)) begin
          sp[7] = COUNT_PER_DEG;
        end
        queue_scratchpad(sp, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 80);
      end else if (pick < 80) begin
        // truncated read
        k = $urandom_range(1, STORE_DEPTH);
        for (int i = 0; i < k; i++) begin
          push_item(OP_BYTE, 8'($urandom_range(0, 255)),
                    (i == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
        end
      end else if (pick < 90) begin
        push_item(OP_ABSENT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        push_item(OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
    wait_drained();
  endtask

  // Main sequence
  initial begin
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_FAMILY;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_BYTE;
    in_ch.scratch_byte  = 8'h00;
    in_ch.start_of_read = 1'b0;
    out_ch.ready        = 1'b0;
    in_done             = 1'b0;
    no_gaps             = 1'b0;
    stall_requests      = 0;
    stall_served        = 0;
    hold_left           = 0;
    total_queued        = 0;
    items_in            = 0;
    mismatches          = 0;
    good_seen           = 0;
    absent_seen         = 0;
    badcrc_seen         = 0;
    family_sh           = 8'h28;
    invalid_sh          = 16'sh8000;
    count_sh            = 0;
    crc_sh              = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings: sensor lost mid-read
    push_item(OP_BYTE, 8'h00, 1'b1);
    push_item(OP_BYTE, 8'hFF, 1'b0);
    push_item(OP_ABSENT, 8'hFF, 1'b1);
    // partial read abandoned by a new start mark, then a 9-bit reading
    push_item(OP_BYTE, 8'h55, 1'b1);
    push_item(OP_BYTE, 8'hAA, 1'b0);
    queue_scratchpad({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h1F, 8'hFF, 8'h00, 8'h10}, 1'b1, 1'b1);
    // unmarked read right after the ninth byte, with a bad CRC
    queue_scratchpad({8'h00, 8'h80, 8'hFF, 8'h00, 8'h7F, 8'h00, 8'hFF, 8'h01}, 1'b0, 1'b0);
    wait_drained();

    // Directed, legacy family: refinement with count-remain at its top
    write_register(CFG_FAMILY, 16'(FAMILY_LEGACY));
    write_register(CFG_INVALID, 16'h7FFF);
    queue_scratchpad({8'h32, 8'h00, 8'h4B, 8'h46, 8'hFF, 8'hFF, 8'hFF, 8'h10}, 1'b1, 1'b1);
    wait_drained();

    // Random, legacy family, no gaps on either side
    no_gaps = 1'b1;
    run_random_phase(PHASE_ITEMS);
    no_gaps = 1'b0;

    // Random, family zero, with a long output stall to back up the input
    write_register(CFG_FAMILY, 16'h0000);
    write_register(CFG_INVALID, 16'h0000);
    stall_requests++;
    run_random_phase(PHASE_ITEMS);

    write_register(CFG_FAMILY, 16'h00FF);
    write_register(CFG_INVALID, 16'hFFFF);
    run_random_phase(PHASE_ITEMS);

    write_register(CFG_FAMILY, 16'(FAMILY_LEGACY));
    write_register(CFG_INVALID, 16'($urandom_range(0, 65535)));
    run_random_phase(PHASE_ITEMS);

    write_register(CFG_FAMILY, 16'($urandom_range(0, 255)));
    write_register(CFG_INVALID, 16'h8000);
    run_random_phase(PHASE_ITEMS);

    // Anything still expected here never arrived
    mismatches += expected_readings.size();
    $display("Covered %0d input transfers, %0d results: %0d good, %0d no-sensor, %0d CRC errors",
             items_in, good_seen + absent_seen + badcrc_seen, good_seen, absent_seen,
             badcrc_seen);
    $display("Families 0x28, 0x10, 0x00, 0xFF and random; error value at both extremes, 0, -1");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
